@@ hdl/wmfa_pkg.sv @@
// ----------------------------------------------------------------------------
// wmfa_pkg
// Shared types and constants for the word memory first-fit allocator.
// ----------------------------------------------------------------------------
package wmfa_pkg;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 10;
    localparam int DATA_W  = 32;
    localparam int HSIZE_W = 11;
    localparam int ROW_W   = 32;   // occupancy bits per map row
    localparam int ROW_SH  = 5;    // log2 of ROW_W

    typedef enum logic [KIND_W-1:0] {
        K_READ  = 3'd0,
        K_WRITE = 3'd1,
        K_ALLOC = 3'd2,
        K_FREE  = 3'd3,
        K_QUERY = 3'd4,
        K_FIND  = 3'd5
    } t_kind;

    typedef struct packed {
        logic init;   // clear run length and run start
        logic step;   // fold the current row into the run state
    } t_scan_ctl;

endpackage

@@ hdl/wmfa_ram.sv @@
// ----------------------------------------------------------------------------
// wmfa_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wmfa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds while the port is not read
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/wmfa_row_scan.sv @@
// ----------------------------------------------------------------------------
// wmfa_row_scan
// First-fit search unit: folds one 32-bit occupancy row per step into the
// running free-run length and start index, and flags the first fit.
// ----------------------------------------------------------------------------
module wmfa_row_scan #(
    parameter int WORDS = 1024,
    parameter int RBW   = 5
) (
    input  logic                          i_clk,
    input  wmfa_pkg::t_scan_ctl           i_ctl,
    input  logic [RBW-1:0]                i_row,
    input  logic [wmfa_pkg::ROW_W-1:0]    i_bits,
    input  logic [wmfa_pkg::HSIZE_W-1:0]  i_need,
    output logic                          o_hit,
    output logic [wmfa_pkg::IDX_W-1:0]    o_start
);
    import wmfa_pkg::*;

    localparam int RW = $clog2(WORDS + 1);
    localparam int CW = ((RW > HSIZE_W) ? RW : HSIZE_W) + 1;
    localparam int FW = $clog2(WORDS) + 1;
    localparam int PW = RBW + ROW_SH + 1;
    localparam int LV = ROW_SH + 1;

    logic [RW-1:0]     r_run;
    logic [FW-1:0]     r_first;
    logic [RW-1:0]     n_run;
    logic [FW-1:0]     n_first;

    logic [ROW_W-1:0]  occ;
    logic              lv_seen [0:LV-1][0:ROW_W-1];
    logic [ROW_SH-1:0] lv_pos  [0:LV-1][0:ROW_W-1];
    logic [CW-1:0]     run_j   [0:ROW_W-1];
    logic [FW-1:0]     start_j [0:ROW_W-1];
    logic [ROW_W-1:0]  hit_j;
    logic [FW-1:0]     sel_start;
    logic [FW+IDX_W-1:0] start_x;

    // last occupied bit at or below each position, by prefix doubling
    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            // words past the end of memory count as occupied
            occ[j] = i_bits[j] |
                     (PW'({i_row, ROW_SH'(j)}) >= PW'(WORDS));
            lv_seen[0][j] = occ[j];
            lv_pos[0][j]  = ROW_SH'(j);
        end
        for (int s = 0; s < ROW_SH; s++) begin
            for (int j = 0; j < ROW_W; j++) begin
                if (j >= (1 << s) && !lv_seen[s][j]) begin
                    lv_seen[s+1][j] = lv_seen[s][j - (1 << s)];
                    lv_pos[s+1][j]  = lv_pos[s][j - (1 << s)];
                end else begin
                    lv_seen[s+1][j] = lv_seen[s][j];
                    lv_pos[s+1][j]  = lv_pos[s][j];
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            if (lv_seen[LV-1][j]) begin
                run_j[j]   = CW'(j) - CW'(lv_pos[LV-1][j]);
                start_j[j] = FW'({i_row, lv_pos[LV-1][j]}) + FW'(1);
            end else begin
                run_j[j]   = CW'(r_run) + CW'(j) + CW'(1);
                start_j[j] = r_first;
            end
            hit_j[j] = !occ[j] && (run_j[j] >= CW'(i_need));
        end
        o_hit     = 1'b0;
        sel_start = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (hit_j[j]) begin
                o_hit     = 1'b1;
                sel_start = start_j[j];
            end
        end
        if (lv_seen[LV-1][ROW_W-1]) begin
            n_run   = RW'(CW'(ROW_W - 1) - CW'(lv_pos[LV-1][ROW_W-1]));
            n_first = FW'({i_row, lv_pos[LV-1][ROW_W-1]}) + FW'(1);
        end else begin
            n_run   = RW'(CW'(r_run) + CW'(ROW_W));
            n_first = r_first;
        end
    end

    assign start_x = (FW + IDX_W)'(sel_start);
    assign o_start = start_x[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_run   <= '0;
            r_first <= '0;
        end else if (i_ctl.step) begin
            r_run   <= n_run;
            r_first <= n_first;
        end
    end

endmodule

@@ hdl/word_memory_first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// word_memory_first_fit_allocator
// Word store with per-word occupancy map and first-fit free-run search.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one command word (kind, word index,
// write data, hole size); output channel o_valid/i_ready returns one result
// word per command, in order. One command is worked at a time.
// Reads, queries, allocates and frees issue the RAM read at the accepting
// edge and finish from the registered read data.
// A search reads one 32-bit occupancy row per cycle from the map RAM and
// stops at the first fit or after the last row.
// o_ready rises again at the edge that loads the result, so a new command
// is not taken before the previous one has finished.
// After reset a clearing pass zeroes both RAMs, one word a cycle, with
// o_ready low.
// The result register holds while i_ready is low; a new command may still
// be accepted, and its completion waits until the register is free.
// ----------------------------------------------------------------------------
module word_memory_first_fit_allocator #(
    parameter int WORDS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [wmfa_pkg::KIND_W-1:0]         i_kind,
    input  logic [wmfa_pkg::IDX_W-1:0]          i_word_index,
    input  logic signed [wmfa_pkg::DATA_W-1:0]  i_write_data,
    input  logic [wmfa_pkg::HSIZE_W-1:0]        i_hole_size,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wmfa_pkg::DATA_W-1:0]  o_read_word,
    output logic                                o_occupied,
    output logic                                o_hole_found,
    output logic [wmfa_pkg::IDX_W-1:0]          o_hole_start
);
    import wmfa_pkg::*;

    localparam int AW   = $clog2(WORDS);
    localparam int ROWS = (WORDS + ROW_W - 1) / ROW_W;
    localparam int RBW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW   = AW + RBW + IDX_W + ROW_SH;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MEM   = 5'b00100,
        S_FIND  = 5'b01000,
        S_ACK   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_cnt;
    logic                r_out_valid;

    t_kind               r_kind;
    logic [RBW-1:0]      r_occ_row;
    logic [ROW_SH-1:0]   r_bit;
    logic [HSIZE_W-1:0]  r_need;
    logic [RBW-1:0]      r_row;

    logic [DATA_W-1:0]   r_out_word;
    logic                r_out_occ;
    logic                r_out_found;
    logic [IDX_W-1:0]    r_out_start;

    logic                accept;
    logic                out_free;
    logic [XW-1:0]       idx_x;
    logic [XW-1:0]       cnt_x;
    logic                in_ok;
    t_kind               in_kind;

    logic                wr_en, wr_we;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_wdata, wr_q;
    logic                oc_en, oc_we;
    logic [RBW-1:0]      oc_addr;
    logic [ROW_W-1:0]    oc_wdata, oc_q;

    t_scan_ctl           scan_ctl;
    logic                scan_hit;
    logic [IDX_W-1:0]    scan_start;
    logic                last_row;

    logic                done;
    logic [DATA_W-1:0]   res_word;
    logic                res_occ;
    logic                res_found;
    logic [IDX_W-1:0]    res_start;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign idx_x    = XW'(i_word_index);
    assign cnt_x    = XW'(r_cnt);
    assign in_ok    = idx_x < XW'(WORDS);
    assign in_kind  = t_kind'(i_kind);
    assign last_row = (r_row == RBW'(ROWS - 1));

    always_comb begin
        n_state   = r_state;
        wr_en     = 1'b0;
        wr_we     = 1'b0;
        wr_addr   = idx_x[AW-1:0];
        wr_wdata  = i_write_data;
        oc_en     = 1'b0;
        oc_we     = 1'b0;
        oc_addr   = idx_x[RBW+ROW_SH-1:ROW_SH];
        oc_wdata  = oc_q;
        scan_ctl  = '0;
        done      = 1'b0;
        res_word  = '0;
        res_occ   = 1'b0;
        res_found = 1'b0;
        res_start = '0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_we    = 1'b1;
                wr_addr  = r_cnt;
                wr_wdata = '0;
                oc_en    = 1'b1;
                oc_we    = 1'b1;
                oc_addr  = cnt_x[RBW+ROW_SH-1:ROW_SH];
                oc_wdata = '0;
                if (r_cnt == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ACK;
                    unique case (in_kind) inside
                        K_READ: begin
                            if (in_ok) begin
                                wr_en   = 1'b1;
                                n_state = S_MEM;
                            end
                        end
                        K_WRITE: begin
                            wr_en = in_ok;
                            wr_we = in_ok;
                        end
                        K_ALLOC, K_FREE, K_QUERY: begin
                            if (in_ok) begin
                                oc_en   = 1'b1;
                                n_state = S_MEM;
                            end
                        end
                        K_FIND: begin
                            if (i_hole_size != '0) begin
                                oc_en         = 1'b1;
                                oc_addr       = '0;
                                scan_ctl.init = 1'b1;
                                n_state       = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MEM: begin
                oc_addr = r_occ_row;
                if (out_free) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                    // read-modify-write of the addressed map row
                    if (r_kind == K_ALLOC || r_kind == K_FREE) begin
                        oc_en           = 1'b1;
                        oc_we           = 1'b1;
                        oc_wdata[r_bit] = (r_kind == K_ALLOC);
                    end
                    if (r_kind == K_READ) begin
                        res_word = wr_q;
                    end
                    if (r_kind == K_QUERY) begin
                        res_occ = oc_q[r_bit];
                    end
                end
            end
            S_FIND: begin
                oc_addr = r_row + RBW'(1);
                if (scan_hit || last_row) begin
                    if (out_free) begin
                        done      = 1'b1;
                        res_found = scan_hit;
                        res_start = scan_hit ? scan_start : '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    oc_en         = 1'b1;
                    scan_ctl.step = 1'b1;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    done = 1'b1;
                    // only a zero-size search lands here with a hole found
                    res_found = (r_kind == K_FIND);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= in_kind;
            r_occ_row <= idx_x[RBW+ROW_SH-1:ROW_SH];
            r_bit     <= i_word_index[ROW_SH-1:0];
            r_need    <= i_hole_size;
            r_row     <= '0;
        end else if (scan_ctl.step) begin
            r_row <= r_row + RBW'(1);
        end
        if (done) begin
            r_out_word  <= res_word;
            r_out_occ   <= res_occ;
            r_out_found <= res_found;
            r_out_start <= res_start;
        end
    end

    wmfa_ram #(
        .DEPTH (WORDS),
        .WIDTH (DATA_W),
        .AW    (AW)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_en    (wr_en),
        .i_we    (wr_we),
        .i_addr  (wr_addr),
        .i_wdata (wr_wdata),
        .o_rdata (wr_q)
    );

    wmfa_ram #(
        .DEPTH (ROWS),
        .WIDTH (ROW_W),
        .AW    (RBW)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_en    (oc_en),
        .i_we    (oc_we),
        .i_addr  (oc_addr),
        .i_wdata (oc_wdata),
        .o_rdata (oc_q)
    );

    wmfa_row_scan #(
        .WORDS (WORDS),
        .RBW   (RBW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_row   (r_row),
        .i_bits  (oc_q),
        .i_need  (r_need),
        .o_hit   (scan_hit),
        .o_start (scan_start)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_read_word  = r_out_word;
    assign o_occupied   = r_out_occ;
    assign o_hole_found = r_out_found;
    assign o_hole_start = r_out_start;

endmodule

@@ tb/sv/wmfa_checker.sv @@
// ----------------------------------------------------------------------------
// wmfa_checker
// Watches the command and result channels of the word memory first-fit
// allocator, keeps its own copy of the word store and occupancy map, works
// out the result of every accepted command and compares each returned
// result word, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module wmfa_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  logic                                i_cmd_ready,
    input  logic [wmfa_pkg::KIND_W-1:0]         i_kind,
    input  logic [wmfa_pkg::IDX_W-1:0]          i_word_index,
    input  logic signed [wmfa_pkg::DATA_W-1:0]  i_write_data,
    input  logic [wmfa_pkg::HSIZE_W-1:0]        i_hole_size,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic signed [wmfa_pkg::DATA_W-1:0]  i_read_word,
    input  logic                                i_occupied,
    input  logic                                i_hole_found,
    input  logic [wmfa_pkg::IDX_W-1:0]          i_hole_start,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import wmfa_pkg::*;

    localparam int WORDS      = 1024;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_word;
        logic                     occupied;
        logic                     hole_found;
        logic [IDX_W-1:0]         hole_start;
    } t_result;

    logic signed [DATA_W-1:0] stored_words [WORDS];
    logic                     busy_map [WORDS];
    t_result                  results_due [$];
    t_result                  got;
    t_result                  want;
    int                       mismatches;
    int                       results_seen;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Lowest run of at least need free words; the run starts just past the
    // last busy word seen, or at word 0.
    function automatic void first_fit_search(
        input  logic [HSIZE_W-1:0] need,
        output logic               found,
        output logic [IDX_W-1:0]   start
    );
        int run;
        int first;
        found = 1'b0;
        start = '0;
        run   = 0;
        first = 0;
        if (need == 0) begin
            found = 1'b1;
            return;
        end
        for (int w = 0; w < WORDS; w++) begin
            if (busy_map[w]) begin
                run   = 0;
                first = w + 1;
            end else begin
                run++;
                if (run >= need) begin
                    found = 1'b1;
                    start = IDX_W'(first);
                    return;
                end
            end
        end
    endfunction

    // Updates the stores and returns the result word; a 10-bit index is
    // always inside a 1024-word store.
    function automatic t_result apply_command(
        input logic [KIND_W-1:0]        kind,
        input logic [IDX_W-1:0]         idx,
        input logic signed [DATA_W-1:0] data,
        input logic [HSIZE_W-1:0]       size
    );
        t_result          r;
        logic             found;
        logic [IDX_W-1:0] start;
        r = '0;
        case (kind)
            K_READ:  r.read_word = stored_words[idx];
            K_WRITE: stored_words[idx] = data;
            K_ALLOC: busy_map[idx] = 1'b1;
            K_FREE:  busy_map[idx] = 1'b0;
            K_QUERY: r.occupied = busy_map[idx];
            K_FIND: begin
                first_fit_search(size, found, start);
                r.hole_found = found;
                r.hole_start = start;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) begin
                stored_words[w] = '0;
                busy_map[w]     = 1'b0;
            end
            results_due.delete();
        end else begin
            // retire before predicting: a result at this edge belongs to an
            // older command
            if (i_res_valid && i_res_ready) begin
                got.read_word  = i_read_word;
                got.occupied   = i_occupied;
                got.hole_found = i_hole_found;
                got.hole_start = i_hole_start;
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing outstanding",
                                              results_seen));
                end else begin
                    want = results_due.pop_front();
                    if (got.read_word !== want.read_word)
                        report_mismatch($sformatf("result %0d read_word %0d, want %0d",
                                                  results_seen, got.read_word,
                                                  want.read_word));
                    if (got.occupied !== want.occupied)
                        report_mismatch($sformatf("result %0d occupied %b, want %b",
                                                  results_seen, got.occupied,
                                                  want.occupied));
                    if (got.hole_found !== want.hole_found)
                        report_mismatch($sformatf("result %0d hole_found %b, want %b",
                                                  results_seen, got.hole_found,
                                                  want.hole_found));
                    if (got.hole_start !== want.hole_start)
                        report_mismatch($sformatf("result %0d hole_start %0d, want %0d",
                                                  results_seen, got.hole_start,
                                                  want.hole_start));
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                results_due.push_back(apply_command(i_kind, i_word_index,
                                                    i_write_data, i_hole_size));
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the word memory first-fit allocator: a directed set of
// commands covering field extremes and search corner cases, then a random
// mix of allocate/free runs, searches, reads, writes, queries and unused
// kinds, with random idling on both channels. Checking is in wmfa_checker.
// ----------------------------------------------------------------------------
module tb;
    import wmfa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS  = 650;
    localparam int MAX_IDLE      = 17;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] data;
        logic [HSIZE_W-1:0]       size;
    } t_cmd;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [KIND_W-1:0]         i_kind;
    logic [IDX_W-1:0]          i_word_index;
    logic signed [DATA_W-1:0]  i_write_data;
    logic [HSIZE_W-1:0]        i_hole_size;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [DATA_W-1:0]  o_read_word;
    logic                      o_occupied;
    logic                      o_hole_found;
    logic [IDX_W-1:0]          o_hole_start;

    int   fail_count;
    int   pending;
    int   cycle_count;
    t_cmd cmd_list [$];

    word_memory_first_fit_allocator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_word_index (i_word_index),
        .i_write_data (i_write_data),
        .i_hole_size  (i_hole_size),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_word  (o_read_word),
        .o_occupied   (o_occupied),
        .o_hole_found (o_hole_found),
        .o_hole_start (o_hole_start)
    );

    wmfa_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_ready  (o_ready),
        .i_kind       (i_kind),
        .i_word_index (i_word_index),
        .i_write_data (i_write_data),
        .i_hole_size  (i_hole_size),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_read_word  (o_read_word),
        .i_occupied   (o_occupied),
        .i_hole_found (o_hole_found),
        .i_hole_start (o_hole_start),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic add_cmd(
        input logic [KIND_W-1:0]        kind,
        input logic [IDX_W-1:0]         idx,
        input logic signed [DATA_W-1:0] data,
        input logic [HSIZE_W-1:0]       size
    );
        t_cmd c;
        c.kind = kind;
        c.idx  = idx;
        c.data = data;
        c.size = size;
        cmd_list.push_back(c);
    endtask

    task automatic build_directed();
        add_cmd(K_WRITE, 10'd0,    32'sh7FFF_FFFF, 11'd0);
        add_cmd(K_WRITE, 10'd1023, 32'sh8000_0000, 11'd2047);
        add_cmd(K_WRITE, 10'd5,    -32'sd1,        11'd0);
        add_cmd(K_READ,  10'd0,    32'sd0,         11'd0);
        add_cmd(K_READ,  10'd1023, 32'sd0,         11'd0);
        add_cmd(K_READ,  10'd5,    32'sd0,         11'd0);
        add_cmd(K_READ,  10'd2,    -32'sd1,        11'd2047);
        // empty map: zero size, whole map, one past it, the top of the field
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd0);
        add_cmd(K_FIND,  10'd1023, 32'sd0,         11'd1024);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd1025);
        add_cmd(K_FIND,  10'd0,    -32'sd1,        11'd2047);
        add_cmd(K_ALLOC, 10'd0,    32'sd0,         11'd0);
        add_cmd(K_QUERY, 10'd0,    32'sd0,         11'd0);
        add_cmd(K_QUERY, 10'd1,    32'sd0,         11'd0);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd1);
        add_cmd(K_ALLOC, 10'd1023, 32'sd0,         11'd0);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd1023);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd1022);
        add_cmd(K_ALLOC, 10'd512,  32'sd0,         11'd0);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd600);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd511);
        add_cmd(K_FREE,  10'd0,    32'sd0,         11'd0);
        add_cmd(K_FIND,  10'd0,    32'sd0,         11'd1);
        add_cmd(K_QUERY, 10'd0,    32'sd0,         11'd0);
        add_cmd(KIND_SPARE_A, 10'd1023, -32'sd1,   11'd2047);
        add_cmd(KIND_SPARE_B, 10'd512,  32'sh8000_0000, 11'd1024);
        add_cmd(K_FREE,  10'd512,  32'sd0,         11'd0);
        add_cmd(K_FREE,  10'd1023, 32'sd0,         11'd0);
    endtask

    // Allocate and free runs fragment the map so that searches land on many
    // different holes; unused fields carry random noise throughout.
    task automatic build_random();
        int               made;
        int               pick;
        int               base;
        int               len;
        logic [HSIZE_W-1:0] need;
        logic [IDX_W-1:0]   idx;
        made = 0;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 1023))
                                        : IDX_W'($urandom_range(0, 15));
            if (pick < 28) begin
                base = $urandom_range(0, 1023);
                len  = $urandom_range(1, 48);
                for (int j = 0; j < len; j++) begin
                    add_cmd(pick < 16 ? K_ALLOC : K_FREE, IDX_W'(base + j),
                            $urandom, HSIZE_W'($urandom));
                end
                made += len;
            end else begin
                if (pick < 48) begin
                    case ($urandom_range(0, 19))
                        0:       need = '0;
                        1, 2:    need = HSIZE_W'($urandom_range(1025, 2047));
                        3, 4, 5, 6, 7: need = HSIZE_W'($urandom_range(1, 1024));
                        default: need = HSIZE_W'($urandom_range(1, 40));
                    endcase
                    add_cmd(K_FIND, IDX_W'($urandom), $urandom, need);
                end else if (pick < 60) begin
                    add_cmd(K_QUERY, IDX_W'($urandom), $urandom, HSIZE_W'($urandom));
                end else if (pick < 73) begin
                    add_cmd(K_WRITE, idx, $urandom, HSIZE_W'($urandom));
                end else if (pick < 86) begin
                    add_cmd(K_READ, idx, $urandom, HSIZE_W'($urandom));
                end else if (pick < 91) begin
                    add_cmd($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B,
                            IDX_W'($urandom), $urandom, HSIZE_W'($urandom));
                end else begin
                    add_cmd($urandom_range(0, 1) ? K_ALLOC : K_FREE,
                            IDX_W'($urandom), $urandom, HSIZE_W'($urandom));
                end
                made++;
            end
        end
    endtask

    task automatic send_cmd(input t_cmd c, input int gap);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind       = c.kind;
        i_word_index = c.idx;
        i_write_data = c.data;
        i_hole_size  = c.size;
        i_valid      = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // result side: own stall per word, with stretches of none
    initial begin
        int stall;
        int res_no;
        i_ready = 1'b0;
        res_no  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = (res_no % 90 < 15) ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
            res_no++;
        end
    end

    initial begin
        int gap;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = K_READ;
        i_word_index = '0;
        i_write_data = '0;
        i_hole_size  = '0;
        build_directed();
        build_random();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (cmd_list[n]) begin
            gap = (n % 100 < 20) ? 0 : $urandom_range(0, MAX_IDLE);
            send_cmd(cmd_list[n], gap);
        end
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/wmfa_pkg.sv
hdl/wmfa_ram.sv
hdl/wmfa_row_scan.sv
hdl/word_memory_first_fit_allocator.sv
tb/sv/wmfa_checker.sv
tb/sv/tb.sv
